// ===== rtl/fasl_pkg.sv =====
// Shared types, constants and helpers for the four-axis slew and clamp limiter.
`default_nettype none

package fasl_pkg;

  localparam int AXES               = 4;
  localparam int STAMP_W            = 32;
  localparam int CFG_W              = 64;
  localparam int CFG_ADDR_W         = 2;
  localparam int VALUE_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_LIMITS  = 2'd0,
    CFG_MAX_LIMITS  = 2'd1,
    CFG_RATE_LIMITS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic rate_hit;
    logic max_hit;
    logic min_hit;
  } lane_flags_t;

  // Replicate one lane value into each of the AXES lanes that fits in a register word.
  function automatic logic [CFG_W-1:0] lane_fill(input logic [CFG_W-1:0] v, input int vbits);
    logic [CFG_W-1:0] r;
    r = '0;
    for (int k = 0; k < AXES; k++) begin
      if (k * vbits < CFG_W) begin
        r = r | (v << (k * vbits));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fasl_cfg.sv =====
// Limit register file: per-lane minimum, maximum and rate words.
`default_nettype none

module fasl_cfg #(
  parameter int VALUE_BITS = fasl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [fasl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [fasl_pkg::CFG_W-1:0]       cfg_wdata,
  output logic      [fasl_pkg::CFG_W-1:0]       min_limits,
  output logic      [fasl_pkg::CFG_W-1:0]       max_limits,
  output logic      [fasl_pkg::CFG_W-1:0]       rate_limits
);

  localparam logic [fasl_pkg::CFG_W-1:0] SIGN_BIT =
    fasl_pkg::CFG_W'(1) << (VALUE_BITS - 1);
  localparam logic [fasl_pkg::CFG_W-1:0] MIN_RST =
    fasl_pkg::lane_fill(SIGN_BIT, VALUE_BITS);
  localparam logic [fasl_pkg::CFG_W-1:0] MAX_RST =
    fasl_pkg::lane_fill(SIGN_BIT - fasl_pkg::CFG_W'(1), VALUE_BITS);

  logic [fasl_pkg::CFG_W-1:0] min_limits_r;
  logic [fasl_pkg::CFG_W-1:0] max_limits_r;
  logic [fasl_pkg::CFG_W-1:0] rate_limits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_limits_r  <= MIN_RST;
      max_limits_r  <= MAX_RST;
      rate_limits_r <= '1;
    end else if (cfg_wr_en) begin
      case (fasl_pkg::cfg_idx_t'(cfg_addr))
        fasl_pkg::CFG_MIN_LIMITS:  min_limits_r  <= cfg_wdata;
        fasl_pkg::CFG_MAX_LIMITS:  max_limits_r  <= cfg_wdata;
        fasl_pkg::CFG_RATE_LIMITS: rate_limits_r <= cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign min_limits  = min_limits_r;
  assign max_limits  = max_limits_r;
  assign rate_limits = rate_limits_r;

endmodule

`default_nettype wire

// ===== rtl/fasl_lane.sv =====
// One axis: slew limit against the previous output, then clamp to max and min.
`default_nettype none

module fasl_lane #(
  parameter int VALUE_BITS     = fasl_pkg::VALUE_BITS_DEF,
  parameter int TIME_FRAC_BITS = fasl_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic signed [VALUE_BITS-1:0]         req,
  input  wire logic signed [VALUE_BITS-1:0]         old,
  input  wire logic signed [VALUE_BITS-1:0]         mx,
  input  wire logic signed [VALUE_BITS-1:0]         mn,
  input  wire logic        [VALUE_BITS-1:0]         rate,
  input  wire logic        [fasl_pkg::STAMP_W-1:0]  dt,
  output logic signed      [VALUE_BITS-1:0]         val,
  output fasl_pkg::lane_flags_t                     flags
);

  localparam int PROD_W = VALUE_BITS + fasl_pkg::STAMP_W;

  logic        [PROD_W-1:0]     prod;
  logic signed [VALUE_BITS:0]   diff;
  logic        [VALUE_BITS:0]   mag;
  logic        [PROD_W-1:0]     mag_sh;
  logic                         limited;
  logic        [VALUE_BITS:0]   step;
  logic signed [VALUE_BITS+1:0] old_ext;
  logic signed [VALUE_BITS+1:0] step_ext;
  logic signed [VALUE_BITS+1:0] slew;
  logic signed [VALUE_BITS-1:0] v_slew;
  logic                         over_max;
  logic signed [VALUE_BITS-1:0] v_max;
  logic                         under_min;

  assign prod    = PROD_W'(rate) * PROD_W'(dt);
  assign diff    = (VALUE_BITS+1)'(req) - (VALUE_BITS+1)'(old);
  assign mag     = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
  assign mag_sh  = PROD_W'(mag) << TIME_FRAC_BITS;
  assign limited = mag_sh > prod;

  // When limited the allowed step is below mag, so it fits in VALUE_BITS+1 bits.
  assign step     = prod[TIME_FRAC_BITS +: VALUE_BITS+1];
  assign old_ext  = (VALUE_BITS+2)'(old);
  assign step_ext = $signed({1'b0, step});
  assign slew     = (diff > 0) ? old_ext + step_ext : old_ext - step_ext;
  assign v_slew   = limited ? slew[VALUE_BITS-1:0] : req;

  assign over_max  = v_slew > mx;
  assign v_max     = over_max ? mx : v_slew;
  assign under_min = v_max < mn;
  assign val       = under_min ? mn : v_max;

  assign flags.rate_hit = limited;
  assign flags.max_hit  = over_max;
  assign flags.min_hit  = under_min;

endmodule

`default_nettype wire

// ===== rtl/four_axis_slew_and_clamp_limiter.sv =====
// Top level: input register, four axis lanes and result register.
//
//  channel   dir  handshake            payload
//  in_       in   tvalid / tready      tdata: stamp, thrust, pitch, roll, yaw
//  out_      out  tvalid / tready      tdata: thrust, pitch, roll, yaw, stamp
//                                      tuser: rate_hits, max_hits, min_hits, first_item
//  cfg_      in   wr_en (no wait)      addr, wdata
//
// Items pass the input and result registers; one item per cycle if out_tready is high.
// The item's dt and priming flag are taken at the input transfer; the four
// lanes then work from the input register to the result register, where the
// stored per-axis values are updated. Reset is synchronous: the first item
// after reset primes the block and yields zero axes. A stalled output holds
// the result register and, behind it, the input register.
`default_nettype none

module four_axis_slew_and_clamp_limiter #(
  parameter  int VALUE_BITS     = fasl_pkg::VALUE_BITS_DEF,
  parameter  int TIME_FRAC_BITS = fasl_pkg::TIME_FRAC_BITS_DEF,
  localparam int DATA_W = ((fasl_pkg::STAMP_W + fasl_pkg::AXES*VALUE_BITS + 7) / 8) * 8,
  localparam int USER_W = 3*fasl_pkg::AXES + 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // stamp, thrust_in, pitch_in, roll_in, yaw_in, zero fill
  input  wire logic [DATA_W-1:0]               in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // thrust_out, pitch_out, roll_out, yaw_out, stamp_out, zero fill
  output logic      [DATA_W-1:0]               out_tdata,
  // rate_hits, max_hits, min_hits, first_item
  output logic      [USER_W-1:0]               out_tuser,
  input  wire logic                            cfg_wr_en,
  input  wire logic [fasl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [fasl_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int AX    = fasl_pkg::AXES;
  localparam int SW    = fasl_pkg::STAMP_W;
  localparam int PAD_W = (AX*VALUE_BITS > fasl_pkg::CFG_W) ? AX*VALUE_BITS : fasl_pkg::CFG_W;

  logic [fasl_pkg::CFG_W-1:0] min_limits;
  logic [fasl_pkg::CFG_W-1:0] max_limits;
  logic [fasl_pkg::CFG_W-1:0] rate_limits;
  logic [PAD_W-1:0]           min_pad;
  logic [PAD_W-1:0]           max_pad;
  logic [PAD_W-1:0]           rate_pad;

  fasl_cfg #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .min_limits  (min_limits),
    .max_limits  (max_limits),
    .rate_limits (rate_limits)
  );

  // lanes past bit 63 read as zero
  assign min_pad  = PAD_W'(min_limits);
  assign max_pad  = PAD_W'(max_limits);
  assign rate_pad = PAD_W'(rate_limits);

  // input side tracking
  logic          in_xfer;
  logic          primed_r;
  logic [SW-1:0] last_stamp_r;

  // input register
  logic                         s1_vld_r;
  logic                         s1_first_r;
  logic [SW-1:0]                s1_stamp_r;
  logic [SW-1:0]                s1_dt_r;
  logic signed [VALUE_BITS-1:0] s1_val_r [AX];

  // result register and per-axis state
  logic                         out_vld_r;
  logic                         out_first_r;
  logic [SW-1:0]                out_stamp_r;
  logic signed [VALUE_BITS-1:0] out_val_r   [AX];
  logic [AX-1:0]                out_rate_r;
  logic [AX-1:0]                out_max_r;
  logic [AX-1:0]                out_min_r;
  logic signed [VALUE_BITS-1:0] last_val_r  [AX];

  logic                         advance;
  logic signed [VALUE_BITS-1:0] lane_val    [AX];
  fasl_pkg::lane_flags_t        lane_flags  [AX];

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      last_stamp_r <= '0;
      s1_vld_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        primed_r     <= 1'b1;
        last_stamp_r <= in_tdata[SW-1:0];
        s1_vld_r     <= 1'b1;
      end else if (advance) begin
        s1_vld_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_first_r <= !primed_r;
      s1_stamp_r <= in_tdata[SW-1:0];
      s1_dt_r    <= in_tdata[SW-1:0] - last_stamp_r;
      for (int k = 0; k < AX; k++) begin
        s1_val_r[k] <= in_tdata[SW + k*VALUE_BITS +: VALUE_BITS];
      end
    end
  end

  for (genvar k = 0; k < AX; k++) begin : g_lane
    fasl_lane #(
      .VALUE_BITS     (VALUE_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_lane (
      .req   (s1_val_r[k]),
      .old   (last_val_r[k]),
      .mx    (max_pad[k*VALUE_BITS +: VALUE_BITS]),
      .mn    (min_pad[k*VALUE_BITS +: VALUE_BITS]),
      .rate  (rate_pad[k*VALUE_BITS +: VALUE_BITS]),
      .dt    (s1_dt_r),
      .val   (lane_val[k]),
      .flags (lane_flags[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      for (int k = 0; k < AX; k++) begin
        last_val_r[k] <= '0;
      end
    end else begin
      if (advance) begin
        out_vld_r <= 1'b1;
        for (int k = 0; k < AX; k++) begin
          // priming item stores the raw command
          last_val_r[k] <= s1_first_r ? s1_val_r[k] : lane_val[k];
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_first_r <= s1_first_r;
      out_stamp_r <= s1_stamp_r;
      for (int k = 0; k < AX; k++) begin
        out_val_r[k]  <= s1_first_r ? '0 : lane_val[k];
        out_rate_r[k] <= !s1_first_r && lane_flags[k].rate_hit;
        out_max_r[k]  <= !s1_first_r && lane_flags[k].max_hit;
        out_min_r[k]  <= !s1_first_r && lane_flags[k].min_hit;
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < AX; k++) begin
      out_tdata[k*VALUE_BITS +: VALUE_BITS] = out_val_r[k];
    end
    out_tdata[AX*VALUE_BITS +: SW] = out_stamp_r;
  end

  assign out_tuser  = {out_first_r, out_min_r, out_max_r, out_rate_r};
  assign out_tvalid = out_vld_r;

endmodule

`default_nettype wire
